FILE: src/assert_macros.svh
// Assertion macros shared by the motor safety monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a implies b in the same cycle, checked out of reset.
`define AST_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Property a implies b in the following cycle, checked out of reset.
`define AST_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

FILE: src/msm_pkg.sv
// Shared constants, types and functions of the motor safety monitor.
package msm_pkg;

    localparam int MOTORS    = 8;
    localparam int MOT_W     = 3;
    localparam int IDX_W     = 4;
    localparam int KINDS     = 7;
    localparam int LIMITS    = 5;
    localparam int LIM_DEPTH = MOTORS * LIMITS;
    localparam int LIM_AW    = 6;
    localparam int VAL_W     = 16;
    localparam int CNT_W     = 32;
    localparam int IN_W      = 96;
    localparam int OUT_W     = 144;

    localparam logic [3:0] OP_CHECK   = 4'd0;
    localparam logic [3:0] OP_TICK    = 4'd1;
    localparam logic [3:0] OP_FEED    = 4'd2;
    localparam logic [3:0] OP_LINK_OK = 4'd3;
    localparam logic [3:0] OP_ESTOP   = 4'd4;
    localparam logic [3:0] OP_ES_RST  = 4'd5;
    localparam logic [3:0] OP_CLR_T   = 4'd6;
    localparam logic [3:0] OP_CLR_ALL = 4'd7;
    localparam logic [3:0] OP_WR_LIM  = 4'd8;

    localparam logic [2:0] K_LINK  = 3'd4;
    localparam logic [2:0] K_ESTOP = 3'd5;
    localparam logic [2:0] K_WDOG  = 3'd6;

    localparam logic [2:0] FAIL_NONE  = 3'd0;
    localparam logic [2:0] FAIL_POS   = 3'd1;
    localparam logic [2:0] FAIL_VEL   = 3'd2;
    localparam logic [2:0] FAIL_TRQ   = 3'd3;
    localparam logic [2:0] FAIL_TEMP  = 3'd4;
    localparam logic [2:0] FAIL_MOTOR = 3'd5;

    localparam logic [2:0] LIM_PMIN = 3'd0;
    localparam logic [2:0] LIM_PMAX = 3'd1;
    localparam logic [2:0] LIM_VEL  = 3'd2;
    localparam logic [2:0] LIM_TRQ  = 3'd3;
    localparam logic [2:0] LIM_TEMP = 3'd4;

    localparam logic [1:0] CFG_MOTORS = 2'd0;
    localparam logic [1:0] CFG_WDOG   = 2'd1;
    localparam logic [1:0] CFG_LINK   = 2'd2;

    typedef struct packed {
        logic             load;
        logic             lim_rd;
        logic             lim_cmp;
        logic [2:0]       lim_k;
        logic             chk_eval;
        logic             wd_tick;
        logic             link_step;
        logic [MOT_W-1:0] link_idx;
        logic             apply_op;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic [3:0]       op;
        logic             motor_ok;
        logic [IDX_W-1:0] nvalid;
        logic             out_busy;
    } t_sts;

    function automatic logic [VAL_W-1:0] lim_reset(input logic [2:0] k);
        logic [VAL_W-1:0] v;
        unique case (k)
            LIM_PMIN: v = -16'sd804;
            LIM_PMAX: v = 16'sd804;
            LIM_VEL:  v = 16'sd2560;
            LIM_TRQ:  v = 16'sd1280;
            default:  v = 16'sd20480;
        endcase
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

FILE: src/msm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: src/msm_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module msm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  msm_pkg::t_sts i_sts,
    output msm_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_LIM  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_WDOG = 3'd4;
    localparam logic [2:0] S_LINK = 3'd5;
    localparam logic [2:0] S_OP   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                r_state, n_state;
    logic [2:0]                r_k, n_k;
    logic [msm_pkg::MOT_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_idx   <= n_idx;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.lim_k    = r_k;
        o_cmd.link_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_k   = '0;
                n_idx = '0;
                case (i_sts.op)
                    msm_pkg::OP_CHECK: n_state = i_sts.motor_ok ? S_LIM : S_EVAL;
                    msm_pkg::OP_TICK:  n_state = S_WDOG;
                    default:           n_state = S_OP;
                endcase
            end
            S_LIM: begin
                o_cmd.lim_rd  = (r_k < 3'(msm_pkg::LIMITS));
                o_cmd.lim_cmp = (r_k != 3'd0);
                n_k = r_k + 3'd1;
                if (r_k == 3'(msm_pkg::LIMITS)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.chk_eval = 1'b1;
                n_state        = S_OUT;
            end
            S_WDOG: begin
                o_cmd.wd_tick = 1'b1;
                n_state = (i_sts.nvalid == '0) ? S_OUT : S_LINK;
            end
            S_LINK: begin
                o_cmd.link_step = 1'b1;
                n_idx = r_idx + 1'b1;
                if ({1'b0, r_idx} + 4'd1 == i_sts.nvalid) begin
                    n_state = S_OUT;
                end
            end
            S_OP: begin
                o_cmd.apply_op = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: src/msm_datapath.sv
// Datapath holding limits, flags, silence counters, event counters and the result.
module msm_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msm_pkg::t_cmd               i_cmd,
    output msm_pkg::t_sts               o_sts,
    input  logic [3:0]                  i_s_tuser,
    input  logic [msm_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                        i_cfg_valid,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [msm_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [msm_pkg::OUT_W-1:0]   o_m_tdata
);
    localparam int MW = msm_pkg::MOT_W;
    localparam int CW = msm_pkg::CNT_W;

    logic [3:0]                  r_op;
    logic [3:0]                  r_motor;
    logic signed [15:0]          r_pos, r_vel, r_trq, r_tmp, r_lval;
    logic [2:0]                  r_sel, r_kind;
    logic                        r_all;

    logic [3:0]                  r_miu;
    logic [CW-1:0]               r_wd_lim, r_link_lim;

    logic [msm_pkg::KINDS-1:0]   r_flags [msm_pkg::MOTORS];
    logic [msm_pkg::KINDS-1:0]   n_flags [msm_pkg::MOTORS];
    logic [CW-1:0]               r_link [msm_pkg::MOTORS];
    logic [CW-1:0]               n_link [msm_pkg::MOTORS];
    logic [CW-1:0]               r_wd, n_wd;
    logic                        r_estop, n_estop;
    logic [CW-1:0]               r_c_new, n_c_new, r_c_es, n_c_es;
    logic [CW-1:0]               r_c_wd, n_c_wd, r_c_link, n_c_link;
    logic [msm_pkg::LIM_DEPTH-1:0] r_lvld, n_lvld;

    logic [2:0]                  r_fail, n_fail;
    logic                        r_within, n_within;
    logic                        r_rd_vld;
    logic [2:0]                  r_rd_k;

    logic                        r_oval;
    logic [msm_pkg::OUT_W-1:0]   r_odata;

    logic [msm_pkg::IDX_W-1:0]   nvalid;
    logic                        motor_ok;
    logic [msm_pkg::LIM_AW-1:0]  base, raddr, waddr;
    logic                        we;
    logic [msm_pkg::VAL_W-1:0]   ram_q, lim;
    logic signed [16:0]          lim_x, pos_x, vel_a, trq_a, tmp_x;
    logic                        cmp_bad;
    logic [MW-1:0]               fa;
    logic [2:0]                  rk;
    logic                        rdo;
    logic [CW-1:0]               ls_inc, wd_inc;
    logic                        any;
    logic [msm_pkg::KINDS-1:0]   mflags;

    assign nvalid   = (r_miu < 4'(msm_pkg::MOTORS)) ? r_miu : 4'(msm_pkg::MOTORS);
    assign motor_ok = r_motor < nvalid;
    assign base     = msm_pkg::LIM_AW'(r_motor[MW-1:0]) * msm_pkg::LIM_AW'(msm_pkg::LIMITS);
    assign raddr    = base + msm_pkg::LIM_AW'(i_cmd.lim_k);
    assign waddr    = base + msm_pkg::LIM_AW'(r_sel);
    assign we       = i_cmd.apply_op && (r_op == msm_pkg::OP_WR_LIM) && motor_ok
                      && (r_sel < 3'(msm_pkg::LIMITS));

    msm_ram #(.WIDTH(msm_pkg::VAL_W), .DEPTH(msm_pkg::LIM_DEPTH)) u_lim_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_lval),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign lim   = r_rd_vld ? ram_q : msm_pkg::lim_reset(r_rd_k);
    assign lim_x = 17'(signed'(lim));
    assign pos_x = 17'(r_pos);
    assign vel_a = (r_vel < 0) ? -17'(r_vel) : 17'(r_vel);
    assign trq_a = (r_trq < 0) ? -17'(r_trq) : 17'(r_trq);
    assign tmp_x = 17'(r_tmp);

    always_comb begin
        case (r_rd_k)
            msm_pkg::LIM_PMIN: cmp_bad = pos_x < lim_x;
            msm_pkg::LIM_PMAX: cmp_bad = pos_x > lim_x;
            msm_pkg::LIM_VEL:  cmp_bad = vel_a > lim_x;
            msm_pkg::LIM_TRQ:  cmp_bad = trq_a > lim_x;
            default:           cmp_bad = tmp_x > lim_x;
        endcase
    end

    assign fa     = i_cmd.link_step ? i_cmd.link_idx :
                    (i_cmd.wd_tick ? '0 : r_motor[MW-1:0]);
    assign ls_inc = msm_pkg::sat_inc(r_link[fa]);
    assign wd_inc = msm_pkg::sat_inc(r_wd);
    assign rk     = (r_fail == msm_pkg::FAIL_NONE) ? 3'd0 : r_fail - 3'd1;
    assign rdo    = (i_cmd.chk_eval && motor_ok && r_fail != msm_pkg::FAIL_NONE)
                 || (i_cmd.wd_tick && wd_inc > r_wd_lim)
                 || (i_cmd.link_step && ls_inc > r_link_lim);

    always_comb begin
        logic [2:0] kind;
        kind = i_cmd.link_step ? msm_pkg::K_LINK :
               (i_cmd.wd_tick ? msm_pkg::K_WDOG : rk);
        n_flags  = r_flags;
        n_link   = r_link;
        n_wd     = r_wd;
        n_estop  = r_estop;
        n_c_new  = r_c_new;
        n_c_es   = r_c_es;
        n_c_wd   = r_c_wd;
        n_c_link = r_c_link;
        n_lvld   = r_lvld;
        n_fail   = r_fail;
        n_within = r_within;
        if (i_cmd.load) begin
            n_fail   = msm_pkg::FAIL_NONE;
            n_within = 1'b0;
        end
        if (i_cmd.lim_cmp && r_fail == msm_pkg::FAIL_NONE && cmp_bad) begin
            n_fail = (r_rd_k == msm_pkg::LIM_PMIN) ? msm_pkg::FAIL_POS : r_rd_k;
        end
        if (i_cmd.chk_eval) begin
            if (!motor_ok) begin
                n_fail = msm_pkg::FAIL_MOTOR;
            end else if (r_fail == msm_pkg::FAIL_NONE) begin
                n_within = 1'b1;
            end
        end
        if (i_cmd.wd_tick) begin
            n_wd = wd_inc;
            if (wd_inc > r_wd_lim) begin
                n_c_wd = msm_pkg::sat_inc(r_c_wd);
            end
        end
        if (i_cmd.link_step) begin
            n_link[fa] = ls_inc;
            if (ls_inc > r_link_lim) begin
                n_c_link = msm_pkg::sat_inc(r_c_link);
            end
        end
        if (rdo && !r_flags[fa][kind]) begin
            n_flags[fa][kind] = 1'b1;
            n_c_new = msm_pkg::sat_inc(r_c_new);
        end
        if (i_cmd.apply_op) begin
            case (r_op)
                msm_pkg::OP_FEED: n_wd = '0;
                msm_pkg::OP_LINK_OK: begin
                    if (motor_ok) begin
                        n_link[r_motor[MW-1:0]] = '0;
                    end
                end
                msm_pkg::OP_ESTOP: begin
                    n_estop = 1'b1;
                    n_c_es  = msm_pkg::sat_inc(r_c_es);
                    if (motor_ok) begin
                        n_flags[r_motor[MW-1:0]][msm_pkg::K_ESTOP] = 1'b1;
                    end
                end
                msm_pkg::OP_ES_RST: begin
                    n_estop = 1'b0;
                    for (int m = 0; m < msm_pkg::MOTORS; m++) begin
                        n_flags[m][msm_pkg::K_ESTOP] = 1'b0;
                    end
                end
                msm_pkg::OP_CLR_T: begin
                    if (r_kind < 3'(msm_pkg::KINDS)) begin
                        if (r_all) begin
                            for (int m = 0; m < msm_pkg::MOTORS; m++) begin
                                n_flags[m][r_kind] = 1'b0;
                            end
                        end else if (r_motor < 4'(msm_pkg::MOTORS)) begin
                            n_flags[r_motor[MW-1:0]][r_kind] = 1'b0;
                        end
                    end
                end
                msm_pkg::OP_CLR_ALL: begin
                    for (int m = 0; m < msm_pkg::MOTORS; m++) begin
                        n_flags[m] = '0;
                    end
                end
                msm_pkg::OP_WR_LIM: begin
                    if (we) begin
                        n_lvld[waddr] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        any = 1'b0;
        for (int m = 0; m < msm_pkg::MOTORS; m++) begin
            any = any | (|r_flags[m]);
        end
        mflags = (r_motor < 4'(msm_pkg::MOTORS)) ? r_flags[r_motor[MW-1:0]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miu      <= 4'd8;
            r_wd_lim   <= CW'(100);
            r_link_lim <= CW'(10);
            for (int m = 0; m < msm_pkg::MOTORS; m++) begin
                r_flags[m] <= '0;
                r_link[m]  <= '0;
            end
            r_wd     <= '0;
            r_estop  <= 1'b0;
            r_c_new  <= '0;
            r_c_es   <= '0;
            r_c_wd   <= '0;
            r_c_link <= '0;
            r_lvld   <= '0;
            r_oval   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    msm_pkg::CFG_MOTORS: r_miu      <= i_cfg_data[3:0];
                    msm_pkg::CFG_WDOG:   r_wd_lim   <= i_cfg_data;
                    msm_pkg::CFG_LINK:   r_link_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            r_flags  <= n_flags;
            r_link   <= n_link;
            r_wd     <= n_wd;
            r_estop  <= n_estop;
            r_c_new  <= n_c_new;
            r_c_es   <= n_c_es;
            r_c_wd   <= n_c_wd;
            r_c_link <= n_c_link;
            r_lvld   <= n_lvld;
            if (i_cmd.out_load) begin
                r_oval <= 1'b1;
            end else if (i_m_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_s_tuser;
            r_motor <= i_s_tdata[3:0];
            r_pos   <= i_s_tdata[19:4];
            r_vel   <= i_s_tdata[35:20];
            r_trq   <= i_s_tdata[51:36];
            r_tmp   <= i_s_tdata[67:52];
            r_sel   <= i_s_tdata[70:68];
            r_lval  <= i_s_tdata[86:71];
            r_kind  <= i_s_tdata[89:87];
            r_all   <= i_s_tdata[90];
        end
        r_fail   <= n_fail;
        r_within <= n_within;
        if (i_cmd.lim_rd) begin
            r_rd_vld <= r_lvld[raddr];
            r_rd_k   <= i_cmd.lim_k;
        end
        if (i_cmd.out_load) begin
            r_odata <= {3'b000, r_c_link, r_c_wd, r_c_es, r_c_new, mflags, any,
                        r_estop, r_fail, r_within};
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.motor_ok = motor_ok;
    assign o_sts.nvalid   = nvalid;
    assign o_sts.out_busy = r_oval && !i_m_tready;
    assign o_m_tvalid     = r_oval;
    assign o_m_tdata      = r_odata;
endmodule

FILE: src/motor_safety_monitor_core.sv
// Top level of the motor safety monitor: controller, datapath and checks.
// One item is processed at a time. Feed, link ok, estop, estop reset, clears and
// limit writes pass the decode, apply and output states; a check reads the five
// limits one per cycle from the limit RAM and compares them (an invalid motor
// skips the reads); a tick steps the watchdog, then sweeps the link-silence
// counters of the motors in use. The result sits in an output register, and a
// new item is taken once that result is loaded. Configuration is always ready.
`include "assert_macros.svh"

module motor_safety_monitor_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // motor[3:0], position[19:4], velocity[35:20], torque[51:36],
    // temperature[67:52], limit_select[70:68], limit_value[86:71],
    // violation_kind[89:87], all_motors[90], zero fill[95:91]
    input  logic [msm_pkg::IN_W-1:0]  s_tdata,
    // operation[3:0]
    input  logic [3:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // within_limits[0], failed_check[3:1], estop_active[4], any_active[5],
    // motor_flags[12:6], new_violations[44:13], estop_events[76:45],
    // watchdog_events[108:77], link_events[140:109], zero fill[143:141]
    output logic [msm_pkg::OUT_W-1:0] m_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_addr,
    input  logic [msm_pkg::CNT_W-1:0] i_cfg_data
);
    msm_pkg::t_cmd cmd;
    msm_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    msm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    `AST_NEXT(a_busy_after_in, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    `AST_IMP(a_within_no_fail, i_clk, i_rst_n, m_tvalid && m_tdata[0], m_tdata[3:1] == 3'd0)
    `AST_IMP(a_estop_counted, i_clk, i_rst_n, m_tvalid && m_tdata[4], m_tdata[76:45] != 32'd0)
endmodule

FILE: dv/motor_safety_monitor_core_test.sv
// Self-checking testbench for the motor safety monitor core with a scoreboard predictor.
module motor_safety_monitor_core_test;

    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  motor;
        logic [15:0] pos;
        logic [15:0] vel;
        logic [15:0] trq;
        logic [15:0] tmp;
        logic [2:0]  sel;
        logic [15:0] lval;
        logic [2:0]  kind;
        logic        all;
    } t_item;

    class monitor_scoreboard;
        logic [15:0] limits [msm_pkg::MOTORS][msm_pkg::LIMITS];
        logic [6:0]  flags [msm_pkg::MOTORS];
        logic [31:0] silence [msm_pkg::MOTORS];
        logic [31:0] wd_silence;
        logic        latch;
        logic [31:0] cnt_new, cnt_es, cnt_wd, cnt_lk;
        logic [3:0]  motors_in_use;
        logic [31:0] wd_limit, lk_limit;
        logic [msm_pkg::OUT_W-1:0] pending [$];
        int errors;

        function void reset_state();
            for (int m = 0; m < msm_pkg::MOTORS; m++) begin
                for (int k = 0; k < msm_pkg::LIMITS; k++) limits[m][k] = lim_default(k);
                flags[m] = 0;
                silence[m] = 0;
            end
            wd_silence = 0; latch = 0;
            cnt_new = 0; cnt_es = 0; cnt_wd = 0; cnt_lk = 0;
            motors_in_use = 8; wd_limit = 100; lk_limit = 10;
            errors = 0;
        endfunction

        function logic [15:0] lim_default(int k);
            case (k)
                msm_pkg::LIM_PMIN: return -16'sd804;
                msm_pkg::LIM_PMAX: return 16'sd804;
                msm_pkg::LIM_VEL:  return 16'sd2560;
                msm_pkg::LIM_TRQ:  return 16'sd1280;
                default: return 16'sd20480;
            endcase
        endfunction

        function logic [31:0] bump(logic [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 1;
        endfunction

        function void raise(int m, int k);
            if (!flags[m][k]) begin
                flags[m][k] = 1'b1;
                cnt_new = bump(cnt_new);
            end
        endfunction

        function void configure(logic [1:0] a, logic [31:0] d);
            case (a)
                msm_pkg::CFG_MOTORS: motors_in_use = d[3:0];
                msm_pkg::CFG_WDOG:   wd_limit = d;
                msm_pkg::CFG_LINK:   lk_limit = d;
                default: ;
            endcase
        endfunction

        function void note_item(t_item it);
            int nvalid, fail;
            logic ok, pass_ok, any;
            logic signed [16:0] p, v, t, tp;
            logic [6:0] mf;
            nvalid = (motors_in_use < msm_pkg::MOTORS) ? motors_in_use : msm_pkg::MOTORS;
            ok = it.motor < nvalid;
            pass_ok = 0; fail = msm_pkg::FAIL_NONE;
            case (it.op)
                msm_pkg::OP_CHECK: begin
                    if (!ok) fail = msm_pkg::FAIL_MOTOR;
                    else begin
                        p = $signed(it.pos); v = $signed(it.vel);
                        t = $signed(it.trq); tp = $signed(it.tmp);
                        if (v < 0) v = -v;
                        if (t < 0) t = -t;
                        if (p < $signed(limits[it.motor][0]) || p > $signed(limits[it.motor][1]))
                            fail = msm_pkg::FAIL_POS;
                        else if (v > $signed(limits[it.motor][2])) fail = msm_pkg::FAIL_VEL;
                        else if (t > $signed(limits[it.motor][3])) fail = msm_pkg::FAIL_TRQ;
                        else if (tp > $signed(limits[it.motor][4])) fail = msm_pkg::FAIL_TEMP;
                        if (fail != msm_pkg::FAIL_NONE) raise(it.motor, fail - 1);
                        else pass_ok = 1;
                    end
                end
                msm_pkg::OP_TICK: begin
                    wd_silence = bump(wd_silence);
                    if (wd_silence > wd_limit) begin
                        cnt_wd = bump(cnt_wd);
                        raise(0, msm_pkg::K_WDOG);
                    end
                    for (int m = 0; m < nvalid; m++) begin
                        silence[m] = bump(silence[m]);
                        if (silence[m] > lk_limit) begin
                            cnt_lk = bump(cnt_lk);
                            raise(m, msm_pkg::K_LINK);
                        end
                    end
                end
                msm_pkg::OP_FEED: wd_silence = 0;
                msm_pkg::OP_LINK_OK: if (ok) silence[it.motor] = 0;
                msm_pkg::OP_ESTOP: begin
                    latch = 1;
                    cnt_es = bump(cnt_es);
                    if (ok) flags[it.motor][msm_pkg::K_ESTOP] = 1'b1;
                end
                msm_pkg::OP_ES_RST: begin
                    latch = 0;
                    for (int m = 0; m < msm_pkg::MOTORS; m++) flags[m][msm_pkg::K_ESTOP] = 1'b0;
                end
                msm_pkg::OP_CLR_T: if (it.kind < msm_pkg::KINDS) begin
                    if (it.all) begin
                        for (int m = 0; m < msm_pkg::MOTORS; m++) flags[m][it.kind] = 1'b0;
                    end else if (it.motor < msm_pkg::MOTORS) flags[it.motor][it.kind] = 1'b0;
                end
                msm_pkg::OP_CLR_ALL: for (int m = 0; m < msm_pkg::MOTORS; m++) flags[m] = 0;
                msm_pkg::OP_WR_LIM:
                    if (ok && it.sel < msm_pkg::LIMITS) limits[it.motor][it.sel] = it.lval;
                default: ;
            endcase
            any = 0;
            for (int m = 0; m < msm_pkg::MOTORS; m++) any |= |flags[m];
            mf = (it.motor < msm_pkg::MOTORS) ? flags[it.motor] : 7'd0;
            pending.insert(pending.size(), {3'b0, cnt_lk, cnt_wd, cnt_es, cnt_new, mf, any,
                                            latch, 3'(fail), pass_ok});
        endfunction

        task check_result(logic [msm_pkg::OUT_W-1:0] got);
            logic [msm_pkg::OUT_W-1:0] exp;
            if (pending.size() == 0) begin
                report("result with no expectation", 0, got);
                return;
            end
            exp = pending.pop_front();
            if (got[0] !== exp[0]) report("within_limits", exp[0], got[0]);
            if (got[3:1] !== exp[3:1]) report("failed_check", exp[3:1], got[3:1]);
            if (got[4] !== exp[4]) report("estop_active", exp[4], got[4]);
            if (got[5] !== exp[5]) report("any_active", exp[5], got[5]);
            if (got[12:6] !== exp[12:6]) report("motor_flags", exp[12:6], got[12:6]);
            if (got[44:13] !== exp[44:13]) report("new_violations", exp[44:13], got[44:13]);
            if (got[76:45] !== exp[76:45]) report("estop_events", exp[76:45], got[76:45]);
            if (got[108:77] !== exp[108:77]) report("watchdog_events", exp[108:77], got[108:77]);
            if (got[140:109] !== exp[140:109]) report("link_events", exp[140:109], got[140:109]);
        endtask

        task report(string what, logic [msm_pkg::OUT_W-1:0] e, logic [msm_pkg::OUT_W-1:0] g);
            errors++;
            $display("mismatch %s: expected %0h got %0h", what, e, g);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic s_tvalid = 0, m_tready = 0, i_cfg_valid = 0;
    logic [msm_pkg::IN_W-1:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic [1:0] i_cfg_addr = '0;
    logic [msm_pkg::CNT_W-1:0] i_cfg_data = '0;
    logic s_tready, m_tvalid, o_cfg_ready;
    logic [msm_pkg::OUT_W-1:0] m_tdata;
    logic calm = 0;
    monitor_scoreboard sb;

    motor_safety_monitor_core dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= calm || ($urandom_range(99) >= 37);
    end

    task automatic send(t_item it);
        s_tuser <= it.op;
        s_tdata <= {5'b0, it.all, it.kind, it.lval, it.sel, it.tmp, it.trq, it.vel,
                    it.pos, it.motor};
        s_tvalid <= 1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_item(it);
        if (!calm) while ($urandom_range(99) < 37) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] a, logic [31:0] d);
        i_cfg_addr <= a; i_cfg_data <= d; i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.configure(a, d);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_item rand_item();
        t_item it;
        it = 95'({$urandom, $urandom, $urandom});
        it.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        if ($urandom_range(3) != 0) it.motor = 4'($urandom_range(8));
        if ($urandom_range(3) != 0) begin
            it.pos = 16'($signed($urandom_range(1800)) - 900);
            it.vel = 16'($signed($urandom_range(6000)) - 3000);
            it.trq = 16'($signed($urandom_range(3000)) - 1500);
            it.tmp = 16'($signed($urandom_range(24000)) - 2000);
        end
        if ($urandom_range(1)) it.sel = 3'($urandom_range(4));
        if ($urandom_range(3) != 0) it.kind = 3'($urandom_range(6));
        return it;
    endfunction

    function automatic t_item mk(logic [3:0] op, logic [3:0] m);
        t_item it;
        it = '0;
        it.op = op; it.motor = m;
        return it;
    endfunction

    initial begin
        t_item it;
        sb = new();
        sb.reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        it = mk(msm_pkg::OP_CHECK, 0); send(it);
        it.pos = 16'h8000; send(it);
        it.pos = 16'h7FFF; send(it);
        it.pos = 0; it.vel = 16'h8000; send(it);
        it.vel = 16'd2560; it.trq = 16'h8000; send(it);
        it.trq = 0; it.tmp = 16'h7FFF; send(it);
        it = mk(msm_pkg::OP_CHECK, 15); send(it);
        for (int op = 1; op < 16; op++) begin
            it = mk(4'(op), 4'(op % 10));
            it.kind = 3'(op % 8); it.sel = 3'(op % 8); it.lval = 16'h8000;
            it.all = op[0];
            send(it);
        end
        drain();
        cfg_write(msm_pkg::CFG_LINK, 0);
        cfg_write(msm_pkg::CFG_WDOG, 0);
        cfg_write(msm_pkg::CFG_MOTORS, 0);
        send(mk(msm_pkg::OP_TICK, 0)); send(mk(msm_pkg::OP_TICK, 0));
        send(mk(msm_pkg::OP_CHECK, 0));
        drain();
        cfg_write(msm_pkg::CFG_MOTORS, 15);
        cfg_write(msm_pkg::CFG_WDOG, 32'hFFFF_FFFF);
        cfg_write(msm_pkg::CFG_LINK, 32'hFFFF_FFFE);
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 3);
            for (int n = 0; n < 250; n++) send(rand_item());
            drain();
            cfg_write(msm_pkg::CFG_MOTORS, 4'($urandom_range(1, 8)));
            cfg_write(msm_pkg::CFG_WDOG, $urandom_range(1, 30));
            cfg_write(msm_pkg::CFG_LINK, (ph == 4) ? 32'd0 : $urandom_range(1, 12));
        end
        calm = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
